// ===== hw/rtl/ssm_pkg.sv =====
// shared constants and codes for the segmented sieve marker
`timescale 1ns / 1ps

package ssm_pkg;

    localparam int DATA_W        = 32;
    localparam int SEG_BITS_DEF  = 65536;
    localparam int WORD_BITS_DEF = 32;

    localparam int REQ_W         = 2;
    localparam int QOFF_W        = 16;
    localparam int S_TDATA_W     = 48;
    localparam int M_TDATA_W     = 8;
    localparam int APB_ADDR_W    = 3;

    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_STRIKE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE   = 2'd3;

    // register index, taken from paddr[2]
    localparam logic REG_SEG_LOW  = 1'b0;
    localparam logic REG_SEG_HIGH = 1'b1;

    localparam logic [DATA_W-1:0] SEG_LOW_RST  = 32'd0;
    localparam logic [DATA_W-1:0] SEG_HIGH_RST = 32'd65535;

endpackage

// ===== hw/rtl/ssm_mod_unit.sv =====
// iterative restoring remainder unit, one quotient bit per cycle
`timescale 1ns / 1ps

module ssm_mod_unit #(
    parameter int W = ssm_pkg::DATA_W
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] rem
);

    localparam int CNT_W = (W > 1) ? $clog2(W) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

    logic [W:0]     rem_reg,  rem_next;
    logic [W-1:0]   dvd_reg,  dvd_next;
    logic [W-1:0]   dsr_reg,  dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [W:0]     shifted;

    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[W-1:0], dvd_reg[W-1]};
        if (start) begin
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = CNT_LAST;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, dsr_reg}) begin
                rem_next = shifted - {1'b0, dsr_reg};
            end else begin
                rem_next = shifted;
            end
            dvd_next = {dvd_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg[W-1:0];

endmodule

// ===== hw/rtl/segmented_sieve_marker.sv =====
// segmented sieve marker: flag store, request sequencer and apb registers
// a query reads one flag word, a clear refills all DEPTH words, and a strike
// runs a setup step (the 32-step remainder unit when seg_low lies above the prime)
// and then a read-modify-write of the flag memory for each struck multiple
// one item at a time; the result register frees the input while a result waits
// reset: after aresetn the flag memory is filled with ones, one word a cycle,
// all DEPTH words (2048 at default sizes) before the first input transfer
`timescale 1ns / 1ps

module segmented_sieve_marker #(
    parameter int SEG_BITS  = ssm_pkg::SEG_BITS_DEF,
    parameter int WORD_BITS = ssm_pkg::WORD_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // apb register port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ssm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ssm_pkg::DATA_W-1:0]       pwdata,
    output logic [ssm_pkg::DATA_W-1:0]       prdata,
    output logic                             pready,
    // request stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ssm_pkg::S_TDATA_W-1:0]    s_tdata,  // prime_value[31:0], query_offset[47:32]
    input  logic [ssm_pkg::REQ_W-1:0]        s_tuser,  // req_type[1:0]
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ssm_pkg::M_TDATA_W-1:0]    m_tdata,  // is_prime[0], zeros[7:1]
    output logic                             m_tuser   // range_error[0]
);

    localparam int W         = ssm_pkg::DATA_W;
    localparam int OFF_W     = W + 1;
    // flags per memory word: largest power of two within WORD_BITS
    localparam int LANE_LOG  = $clog2(WORD_BITS + 1) - 1;
    localparam int LANE_BITS = 1 << LANE_LOG;
    localparam int DEPTH     = (SEG_BITS + LANE_BITS - 1) / LANE_BITS;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int POS_W     = ADDR_W + LANE_LOG;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [W-1:0]      SEG_SPAN  = W'(SEG_BITS);
    localparam int HALF_W    = W / 2;

    typedef enum logic [11:0] {
        S_FILL = 12'b0000_0000_0001,
        S_IDLE = 12'b0000_0000_0010,
        S_PREP = 12'b0000_0000_0100,
        S_MUL  = 12'b0000_0000_1000,
        S_SQ   = 12'b0000_0001_0000,
        S_DIV  = 12'b0000_0010_0000,
        S_RD   = 12'b0000_0100_0000,
        S_WR   = 12'b0000_1000_0000,
        S_QRD  = 12'b0001_0000_0000,
        S_QBIT = 12'b0010_0000_0000,
        S_OUT  = 12'b0100_0000_0000,
        S_SPARE = 12'b1000_0000_0000
    } state_t;

    state_t                  state_reg, state_next;
    logic [W-1:0]            seg_low_reg, seg_low_next;
    logic [W-1:0]            seg_high_reg, seg_high_next;
    logic [ssm_pkg::REQ_W-1:0] req_reg, req_next;
    logic [W-1:0]            prime_reg, prime_next;
    logic [OFF_W-1:0]        off_reg, off_next;
    logic [W-1:0]            span_reg, span_next;
    logic                    ok_reg, ok_next;
    logic                    fill_req_reg, fill_req_next;
    logic [ADDR_W-1:0]       cnt_reg, cnt_next;
    logic [W-1:0]            prod_reg, prod_next;
    logic                    res_prime_reg, res_prime_next;
    logic                    res_err_reg, res_err_next;
    logic                    m_valid_reg, m_valid_next;
    logic                    m_prime_reg, m_prime_next;
    logic                    m_err_reg, m_err_next;

    logic [LANE_BITS-1:0]    mem [DEPTH];
    logic [LANE_BITS-1:0]    rd_data_reg;
    logic                    mem_we, mem_re;
    logic [ADDR_W-1:0]       mem_waddr, mem_raddr;
    logic [LANE_BITS-1:0]    mem_wdata;

    logic                    cfg_write;
    logic                    accept;
    logic                    seg_ok;
    logic [W-1:0]            seg_diff;
    logic [POS_W-1:0]        pos;
    logic [ADDR_W-1:0]       pos_addr;
    logic [LANE_LOG-1:0]     pos_bit;
    logic [LANE_BITS-1:0]    bit_mask;
    logic [LANE_BITS-1:0]    word0;
    logic                    div_start;
    logic                    div_done;
    logic [W-1:0]            div_rem;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_comb begin
        case (paddr[2])
            ssm_pkg::REG_SEG_LOW:  prdata = seg_low_reg;
            ssm_pkg::REG_SEG_HIGH: prdata = seg_high_reg;
            default:               prdata = '0;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign seg_diff = seg_high_reg - seg_low_reg;
    assign seg_ok   = (seg_high_reg >= seg_low_reg) && (seg_diff < SEG_SPAN);

    assign pos      = off_reg[POS_W-1:0];
    assign pos_addr = pos[POS_W-1:LANE_LOG];
    assign pos_bit  = pos[LANE_LOG-1:0];
    assign bit_mask = LANE_BITS'(1) << pos_bit;

    // first word after a clear: the numbers 0 and 1 are not prime
    always_comb begin
        word0 = '1;
        if (seg_low_reg == '0) begin
            word0[0] = 1'b0;
            if (seg_high_reg != '0) begin
                word0[1] = 1'b0;
            end
        end else if (seg_low_reg == W'(1)) begin
            word0[0] = 1'b0;
        end
    end

    ssm_mod_unit #(
        .W (W)
    ) u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (seg_low_reg),
        .divisor  (prime_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    always_comb begin
        state_next     = state_reg;
        seg_low_next   = seg_low_reg;
        seg_high_next  = seg_high_reg;
        req_next       = req_reg;
        prime_next     = prime_reg;
        off_next       = off_reg;
        span_next      = span_reg;
        ok_next        = ok_reg;
        fill_req_next  = fill_req_reg;
        cnt_next       = cnt_reg;
        prod_next      = prod_reg;
        res_prime_next = res_prime_reg;
        res_err_next   = res_err_reg;
        m_valid_next   = m_valid_reg;
        m_prime_next   = m_prime_reg;
        m_err_next     = m_err_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = pos_addr;
        mem_raddr      = pos_addr;
        mem_wdata      = rd_data_reg & ~bit_mask;
        div_start      = 1'b0;

        if (cfg_write) begin
            case (paddr[2])
                ssm_pkg::REG_SEG_LOW:  seg_low_next  = pwdata;
                ssm_pkg::REG_SEG_HIGH: seg_high_next = pwdata;
                default: ;
            endcase
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = (cnt_reg == '0 && fill_req_reg) ? word0 : '1;
                if (cnt_reg == LAST_ADDR) begin
                    state_next = fill_req_reg ? S_OUT : S_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    req_next       = s_tuser;
                    prime_next     = s_tdata[W-1:0];
                    off_next       = OFF_W'(s_tdata[W +: ssm_pkg::QOFF_W]);
                    span_next      = seg_diff;
                    ok_next        = seg_ok;
                    res_prime_next = 1'b0;
                    res_err_next   = 1'b0;
                    state_next     = S_PREP;
                end
            end
            S_PREP: begin
                state_next = S_OUT;
                if (!ok_reg) begin
                    if (req_reg != ssm_pkg::REQ_NONE) begin
                        res_err_next = 1'b1;
                    end
                end else begin
                    case (req_reg)
                        ssm_pkg::REQ_CLEAR: begin
                            cnt_next      = '0;
                            fill_req_next = 1'b1;
                            state_next    = S_FILL;
                        end
                        ssm_pkg::REQ_STRIKE: begin
                            if (prime_reg < W'(2) || prime_reg > seg_high_reg) begin
                                state_next = S_OUT;
                            end else if (seg_low_reg < W'(2) || seg_low_reg == prime_reg) begin
                                // a square beyond 32 bits lies past any segment
                                if (prime_reg[W-1:HALF_W] == '0) begin
                                    state_next = S_MUL;
                                end
                            end else if (seg_low_reg < prime_reg) begin
                                off_next   = {prime_reg, 1'b0} - {1'b0, seg_low_reg};
                                state_next = S_RD;
                            end else begin
                                div_start  = 1'b1;
                                state_next = S_DIV;
                            end
                        end
                        ssm_pkg::REQ_QUERY: begin
                            if (off_reg > {1'b0, span_reg}) begin
                                res_err_next = 1'b1;
                            end else begin
                                state_next = S_QRD;
                            end
                        end
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_MUL: begin
                prod_next  = W'(prime_reg[HALF_W-1:0]) * W'(prime_reg[HALF_W-1:0]);
                state_next = S_SQ;
            end
            S_SQ: begin
                off_next   = {1'b0, prod_reg - seg_low_reg};
                state_next = S_RD;
            end
            S_DIV: begin
                if (div_done) begin
                    off_next   = (div_rem == '0) ? '0 : {1'b0, prime_reg - div_rem};
                    state_next = S_RD;
                end
            end
            S_RD: begin
                if (off_reg > {1'b0, span_reg}) begin
                    state_next = S_OUT;
                end else begin
                    mem_re     = 1'b1;
                    state_next = S_WR;
                end
            end
            S_WR: begin
                mem_we     = 1'b1;
                off_next   = off_reg + {1'b0, prime_reg};
                state_next = S_RD;
            end
            S_QRD: begin
                mem_re     = 1'b1;
                state_next = S_QBIT;
            end
            S_QBIT: begin
                res_prime_next = rd_data_reg[pos_bit];
                state_next     = S_OUT;
            end
            S_OUT: begin
                // result register frees the sequencer once the old transfer is gone
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_prime_next  = res_prime_reg;
                    m_err_next    = res_err_reg;
                    fill_req_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_FILL;
            seg_low_reg  <= ssm_pkg::SEG_LOW_RST;
            seg_high_reg <= ssm_pkg::SEG_HIGH_RST;
            fill_req_reg <= 1'b0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            seg_low_reg  <= seg_low_next;
            seg_high_reg <= seg_high_next;
            fill_req_reg <= fill_req_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        prime_reg     <= prime_next;
        off_reg       <= off_next;
        span_reg      <= span_next;
        ok_reg        <= ok_next;
        prod_reg      <= prod_next;
        res_prime_reg <= res_prime_next;
        res_err_reg   <= res_err_next;
        m_prime_reg   <= m_prime_next;
        m_err_reg     <= m_err_next;
    end

    // flag memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(ssm_pkg::M_TDATA_W-1){1'b0}}, m_prime_reg};
    assign m_tuser  = m_err_reg;

endmodule
